FILE: design/sma_pkg.sv
// sma_pkg: shared constants, opcode and status codes, and the
// controller/datapath command and status structs for the stack machine alu.
// No dependencies.
`default_nettype none

package sma_pkg;

   localparam int STACK_DEPTH = 16;
   localparam int DATA_W      = 32;
   localparam int OP_W        = 3;
   localparam int STATUS_W    = 3;
   localparam int DEPTH_W     = 5;
   localparam int SP_W        = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int DIV_CNT_W   = $clog2(DATA_W);

   typedef enum logic [OP_W-1:0] {
      OP_PUSH = 3'd0,
      OP_ADD  = 3'd1,
      OP_SUB  = 3'd2,
      OP_MUL  = 3'd3,
      OP_DIV  = 3'd4,
      OP_END  = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 3'd0,
      STAT_ENDED     = 3'd1,
      STAT_DIVZERO   = 3'd2,
      STAT_UNDERFLOW = 3'd3,
      STAT_OVERFLOW  = 3'd4,
      STAT_REFUSED   = 3'd5
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic       take;
      logic       push;
      logic       read_ops;
      logic       div_start;
      logic       div_step;
      logic       exec;
      logic       write_back;
      logic       pop2;
      logic       read_top;
      logic       rsp_load;
      op_type     op;
      status_type status;
   } sma_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic full;
      logic lt2;
      logic b_zero;
      logic div_last;
   } sma_stat_type;

endpackage

`default_nettype wire

FILE: design/sma_req_if.sv
// sma_req_if: request channel, valid/ready plus one instruction.
// Depends on sma_pkg.
`default_nettype none

interface sma_req_if import sma_pkg::*;;

   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          operation;
   logic signed [DATA_W-1:0] immediate;

   modport source (output valid, output operation, output immediate, input ready);
   modport sink   (input valid, input operation, input immediate, output ready);

endinterface

`default_nettype wire

FILE: design/sma_rsp_if.sv
// sma_rsp_if: response channel, valid/ready plus status, stack top and depth.
// Depends on sma_pkg.
`default_nettype none

interface sma_rsp_if import sma_pkg::*;;

   logic                     valid;
   logic                     ready;
   logic [STATUS_W-1:0]      status;
   logic signed [DATA_W-1:0] top_value;
   logic [DEPTH_W-1:0]       depth;

   modport source (output valid, output status, output top_value, output depth, input ready);
   modport sink   (input valid, input status, input top_value, input depth, output ready);

endinterface

`default_nettype wire

FILE: design/sma_datapath.sv
// sma_datapath: operand stack memory, stack pointer, alu with iterative
// divider, and the response payload register. Depends on sma_pkg.
`default_nettype none

module sma_datapath import sma_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic signed [DATA_W-1:0] req_immediate,
   input  wire sma_cmd_type              cmd,
   output sma_stat_type                  stat,
   output logic [STATUS_W-1:0]           rsp_status,
   output logic signed [DATA_W-1:0]      rsp_top_value,
   output logic [DEPTH_W-1:0]            rsp_depth
);

   logic [DATA_W-1:0]    mem [STACK_DEPTH];
   logic [SP_W-1:0]      sp_ff, sp_in;
   logic [DATA_W-1:0]    imm_ff;
   logic [DATA_W-1:0]    top_ff;
   logic [DATA_W-1:0]    rd_a_ff, rd_b_ff;
   logic [DATA_W-1:0]    result_ff;
   logic [DATA_W-1:0]    rem_ff, quo_ff, divisor_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic                 neg_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic [DATA_W-1:0]    rsp_top_ff;
   logic [DEPTH_W-1:0]   rsp_depth_ff;

   logic [SP_W-1:0]       sp_m1, sp_m2;
   logic [ADDR_W-1:0]     addr_sp, addr_m1, addr_m2, wr_addr;
   logic                  wr_en;
   logic [DATA_W-1:0]     wr_data;
   logic [DATA_W-1:0]     mag_a, mag_b;
   logic [DATA_W:0]       trial, diff;
   logic [DATA_W-1:0]     product;
   logic [DATA_W-1:0]     alu_out;

   always_comb begin
      sp_m1   = sp_ff - SP_W'(1);
      sp_m2   = sp_ff - SP_W'(2);
      addr_sp = ADDR_W'(sp_ff);
      addr_m1 = ADDR_W'(sp_m1);
      addr_m2 = ADDR_W'(sp_m2);
      wr_en   = cmd.push | cmd.write_back;
      wr_addr = cmd.push ? addr_sp : addr_m2;
      wr_data = cmd.push ? imm_ff : result_ff;
   end

   always_comb begin
      sp_in = sp_ff;
      if (cmd.push) begin
         sp_in = sp_ff + SP_W'(1);
      end else if (cmd.write_back) begin
         sp_in = sp_m1;
      end else if (cmd.pop2) begin
         sp_in = sp_m2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff <= '0;
      end else begin
         sp_ff <= sp_in;
      end
   end

   // stack memory, one write and two registered reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.read_ops) begin
         rd_b_ff <= mem[addr_m1];
         rd_a_ff <= mem[addr_m2];
      end
      if (cmd.push) begin
         top_ff <= imm_ff;
      end else if (cmd.write_back) begin
         top_ff <= result_ff;
      end else if (cmd.read_top) begin
         top_ff <= mem[addr_m1];
      end
   end

   always_comb begin
      mag_a   = rd_a_ff[DATA_W-1] ? -rd_a_ff : rd_a_ff;
      mag_b   = rd_b_ff[DATA_W-1] ? -rd_b_ff : rd_b_ff;
      trial   = {rem_ff, quo_ff[DATA_W-1]};
      diff    = trial - {1'b0, divisor_ff};
      product = rd_a_ff * rd_b_ff;
      case (cmd.op)
         OP_ADD:  alu_out = rd_a_ff + rd_b_ff;
         OP_SUB:  alu_out = rd_a_ff - rd_b_ff;
         OP_MUL:  alu_out = product;
         OP_DIV:  alu_out = neg_ff ? -quo_ff : quo_ff;
         default: alu_out = '0;
      endcase
   end

   // restoring divider on magnitudes, one quotient bit a cycle
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         imm_ff <= req_immediate;
      end
      if (cmd.div_start) begin
         rem_ff     <= '0;
         quo_ff     <= mag_a;
         divisor_ff <= mag_b;
         neg_ff     <= rd_a_ff[DATA_W-1] ^ rd_b_ff[DATA_W-1];
         div_cnt_ff <= DIV_CNT_W'(DATA_W - 1);
      end else if (cmd.div_step) begin
         div_cnt_ff <= div_cnt_ff - DIV_CNT_W'(1);
         if (!diff[DATA_W]) begin
            rem_ff <= diff[DATA_W-1:0];
            quo_ff <= {quo_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_ff <= trial[DATA_W-1:0];
            quo_ff <= {quo_ff[DATA_W-2:0], 1'b0};
         end
      end
      if (cmd.exec) begin
         result_ff <= alu_out;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= cmd.status;
         rsp_top_ff    <= (sp_ff == '0) ? '0 : top_ff;
         rsp_depth_ff  <= DEPTH_W'(sp_ff);
      end
   end

   always_comb begin
      stat.full     = (sp_ff == SP_W'(STACK_DEPTH));
      stat.lt2      = (sp_ff < SP_W'(2));
      stat.b_zero   = (rd_b_ff == '0);
      stat.div_last = (div_cnt_ff == '0);
   end

   assign rsp_status    = rsp_status_ff;
   assign rsp_top_value = rsp_top_ff;
   assign rsp_depth     = rsp_depth_ff;

   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SP_W'(STACK_DEPTH))
      else $error("stack pointer beyond depth");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> !stat.full)
      else $error("push issued on a full stack");

   a_pop_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.write_back || cmd.pop2) |-> !stat.lt2)
      else $error("pop issued with fewer than two entries");

endmodule

`default_nettype wire

FILE: design/sma_controller.sv
// sma_controller: instruction sequencer, halt flag, status code and
// response valid. Drives the datapath by sma_cmd_type. Depends on sma_pkg.
`default_nettype none

module sma_controller import sma_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire logic [OP_W-1:0] req_operation,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   input  wire sma_stat_type    stat,
   output sma_cmd_type          cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_FETCH,
      S_DIV,
      S_EXEC,
      S_WRITE,
      S_DZTOP,
      S_RESPOND
   } state_type;

   state_type  state_ff, state_in;
   op_type     op_ff, op_in;
   status_type status_ff, status_in;
   logic       halted_ff, halted_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      status_in    = status_ff;
      halted_in    = halted_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.op       = op_ff;
      cmd.status   = status_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in     = op_type'(req_operation);
               status_in = STAT_OK;
               cmd.take  = 1'b1;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_RESPOND;
            if (halted_ff) begin
               status_in = STAT_REFUSED;
            end else if (op_ff == OP_PUSH) begin
               if (stat.full) begin
                  status_in = STAT_OVERFLOW;
                  halted_in = 1'b1;
               end else begin
                  cmd.push = 1'b1;
               end
            end else if (op_ff inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV}) begin
               if (stat.lt2) begin
                  status_in = STAT_UNDERFLOW;
                  halted_in = 1'b1;
               end else begin
                  cmd.read_ops = 1'b1;
                  state_in     = S_FETCH;
               end
            end else if (op_ff == OP_END) begin
               status_in = STAT_ENDED;
               halted_in = 1'b1;
            end
            // unused opcodes fall through as a no-op
         end
         S_FETCH: begin
            if (op_ff != OP_DIV) begin
               state_in = S_EXEC;
            end else if (stat.b_zero) begin
               // operands are dropped, new top fetched from below them
               cmd.pop2  = 1'b1;
               status_in = STAT_DIVZERO;
               halted_in = 1'b1;
               state_in  = S_DZTOP;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = S_WRITE;
         end
         S_WRITE: begin
            cmd.write_back = 1'b1;
            state_in       = S_RESPOND;
         end
         S_DZTOP: begin
            cmd.read_top = 1'b1;
            state_in     = S_RESPOND;
         end
         S_RESPOND: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= OP_PUSH;
         status_ff    <= STAT_OK;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         status_ff    <= status_in;
         halted_ff    <= halted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halt flag cleared without reset");

   a_rsp_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("response overwritten before it was taken");

   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_DECODE))
      else $error("accepted request not decoded");

   a_halted_refuses: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECODE && halted_ff) |=> (status_ff == STAT_REFUSED))
      else $error("request not refused while halted");

endmodule

`default_nettype wire

FILE: design/stack_machine_alu.sv
// stack_machine_alu: integer stack-machine alu, one instruction per request.
// Every instruction passes decode then respond; add, sub, mul insert fetch,
// exec, write; divide by zero inserts fetch, dztop; divide is as mul with the
// one-bit-a-cycle divider after fetch. A new request is taken in the cycle after
// the response is loaded. Synchronous reset empties the stack and clears halt.
`default_nettype none

module stack_machine_alu import sma_pkg::*; (
   input wire logic  clock,
   input wire logic  reset,
   sma_req_if.sink   req_port,
   sma_rsp_if.source rsp_port
);

   sma_cmd_type  cmd;
   sma_stat_type stat;

   sma_controller u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_port.valid),
      .req_ready     (req_port.ready),
      .req_operation (req_port.operation),
      .rsp_valid     (rsp_port.valid),
      .rsp_ready     (rsp_port.ready),
      .stat          (stat),
      .cmd           (cmd)
   );

   sma_datapath u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_immediate (req_port.immediate),
      .cmd           (cmd),
      .stat          (stat),
      .rsp_status    (rsp_port.status),
      .rsp_top_value (rsp_port.top_value),
      .rsp_depth     (rsp_port.depth)
   );

endmodule

`default_nettype wire

FILE: bench/tb_stack_machine_alu.sv
// tb_stack_machine_alu: self-checking bench for the stack machine alu, with a
// directed table, then random instruction streams checked against a shadow stack.
// Depends on sma_pkg, sma_req_if, sma_rsp_if and stack_machine_alu.
`timescale 1ns / 100ps

module tb_stack_machine_alu;
   import sma_pkg::*;

   localparam int RANDOM_ITEMS = 1900;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 50;

   // opcodes outside the defined set act as no-ops
   localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

   localparam logic [DATA_W-1:0] INT_MIN   = 32'h8000_0000;
   localparam logic [DATA_W-1:0] INT_MAX   = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] MINUS_ONE = 32'hFFFF_FFFF;

   typedef struct packed {
      status_type          status;
      logic [DATA_W-1:0]   top;
      logic [DEPTH_W-1:0]  depth;
   } outcome_type;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [DATA_W-1:0] imm;
      bit                known;
      outcome_type       res;
   } check_row_type;

   typedef enum int {
      HALT_BY_END,
      HALT_BY_OVERFLOW,
      HALT_BY_UNDERFLOW,
      HALT_BY_DIVZERO
   } halt_kind_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sma_req_if req_bus ();
   sma_rsp_if rsp_bus ();

   stack_machine_alu dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   always #2 clock = ~clock;

   // shadow copy of the operand stack
   logic [DATA_W-1:0] shadow_stack [STACK_DEPTH];
   int unsigned       shadow_sp     = 0;
   bit                shadow_halted = 1'b0;

   outcome_type   expected_outcomes [$];
   check_row_type directed_rows [$];
   int            mismatch_count = 0;
   int            cycle_count    = 0;
   int            burst_left     = 0;

   function automatic outcome_type execute_instr(input logic [OP_W-1:0] op,
                                                 input logic [DATA_W-1:0] imm);
      outcome_type       res;
      status_type        st;
      logic [DATA_W-1:0] a, b, r, ma, mb, q;
      st = STAT_OK;
      r  = '0;
      if (shadow_halted) begin
         st = STAT_REFUSED;
      end else if (op == OP_PUSH) begin
         if (shadow_sp >= STACK_DEPTH) begin
            st = STAT_OVERFLOW;
            shadow_halted = 1'b1;
         end else begin
            shadow_stack[shadow_sp] = imm;
            shadow_sp++;
         end
      end else if (op inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV}) begin
         if (shadow_sp < 2) begin
            st = STAT_UNDERFLOW;
            shadow_halted = 1'b1;
         end else begin
            b = shadow_stack[shadow_sp-1];
            a = shadow_stack[shadow_sp-2];
            shadow_sp -= 2;
            case (op)
               OP_ADD: r = a + b;
               OP_SUB: r = a - b;
               OP_MUL: r = a * b;
               default: begin
                  if (b == '0) begin
                     st = STAT_DIVZERO;
                     shadow_halted = 1'b1;
                  end else begin
                     // divide magnitudes, then restore the sign: truncates toward zero
                     ma = a[DATA_W-1] ? -a : a;
                     mb = b[DATA_W-1] ? -b : b;
                     q  = ma / mb;
                     r  = (a[DATA_W-1] ^ b[DATA_W-1]) ? -q : q;
                  end
               end
            endcase
            if (st == STAT_OK) begin
               shadow_stack[shadow_sp] = r;
               shadow_sp++;
            end
         end
      end else if (op == OP_END) begin
         st = STAT_ENDED;
         shadow_halted = 1'b1;
      end
      res.status = st;
      res.top    = (shadow_sp > 0) ? shadow_stack[shadow_sp-1] : '0;
      res.depth  = DEPTH_W'(shadow_sp);
      return res;
   endfunction

   function automatic check_row_type table_row(input logic [OP_W-1:0] op,
                                               input logic [DATA_W-1:0] imm,
                                               input bit known,
                                               input status_type st,
                                               input logic [DATA_W-1:0] top,
                                               input logic [DEPTH_W-1:0] depth);
      check_row_type row;
      row.op         = op;
      row.imm        = imm;
      row.known      = known;
      row.res.status = st;
      row.res.top    = top;
      row.res.depth  = depth;
      return row;
   endfunction

   // called at a falling edge, returns at the falling edge after the request is taken
   task automatic send_instr(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] imm,
                             input bit known, input outcome_type known_res);
      int          gap;
      outcome_type res;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 45) : $urandom_range(1, 5);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 90)
                                                  : $urandom_range(1, 12);
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      burst_left--;
      req_bus.valid     <= 1'b1;
      req_bus.operation <= op;
      req_bus.immediate <= imm;
      do @(posedge clock); while (!req_bus.ready);
      res = execute_instr(op, imm);
      if (known) res = known_res;
      expected_outcomes.push_back(res);
      @(negedge clock);
   endtask

   // receiver: stall pattern drawn from four modes, redrawn when its random run ends
   initial begin
      int mode;
      int mode_left;
      rsp_bus.ready = 1'b0;
      mode      = 0;
      mode_left = 0;
      forever begin
         @(negedge clock);
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(50, 300);
         end else begin
            mode_left--;
         end
         case (mode)
            0:       rsp_bus.ready <= 1'b1;
            1:       rsp_bus.ready <= ($urandom_range(0, 3) != 0);
            2:       rsp_bus.ready <= ($urandom_range(0, 7) == 0);
            default: rsp_bus.ready <= (cycle_count % 5 != 0);
         endcase
      end
   end

   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_outcomes.size() == 0) begin
            $error("response with no request outstanding: status %0d top %h depth %0d",
                   rsp_bus.status, rsp_bus.top_value, rsp_bus.depth);
            mismatch_count++;
         end else begin
            want = expected_outcomes.pop_front();
            if (rsp_bus.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
               mismatch_count++;
            end
            if (rsp_bus.top_value !== want.top) begin
               $error("top_value: expected %h, got %h", want.top, rsp_bus.top_value);
               mismatch_count++;
            end
            if (rsp_bus.depth !== want.depth) begin
               $error("depth: expected %0d, got %0d", want.depth, rsp_bus.depth);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_stack_machine_alu failed");
         $finish;
      end
   end

   initial begin
      logic [OP_W-1:0]   op;
      logic [DATA_W-1:0] imm;
      int                roll;
      int                push_pct;
      int                taken;
      halt_kind_type     halt_kind;

      req_bus.valid     = 1'b0;
      req_bus.operation = OP_PUSH;
      req_bus.immediate = '0;
      push_pct          = 50;

      // wrap-around, most negative over minus one, truncation, no-op codes
      directed_rows.push_back(table_row(OP_PUSH, INT_MAX, 1, STAT_OK, INT_MAX, 1));
      directed_rows.push_back(table_row(OP_PUSH, 1, 1, STAT_OK, 1, 2));
      directed_rows.push_back(table_row(OP_ADD, MINUS_ONE, 1, STAT_OK, INT_MIN, 1));
      directed_rows.push_back(table_row(OP_PUSH, MINUS_ONE, 1, STAT_OK, MINUS_ONE, 2));
      directed_rows.push_back(table_row(OP_DIV, '0, 1, STAT_OK, INT_MIN, 1));
      directed_rows.push_back(table_row(OP_PUSH, INT_MIN, 1, STAT_OK, INT_MIN, 2));
      directed_rows.push_back(table_row(OP_SUB, INT_MAX, 1, STAT_OK, '0, 1));
      directed_rows.push_back(table_row(OP_SPARE_6, '0, 1, STAT_OK, '0, 1));
      directed_rows.push_back(table_row(OP_SPARE_7, MINUS_ONE, 1, STAT_OK, '0, 1));
      directed_rows.push_back(table_row(OP_PUSH, -32'sd7, 1, STAT_OK, 32'hFFFF_FFF9, 2));
      directed_rows.push_back(table_row(OP_PUSH, 2, 1, STAT_OK, 2, 3));
      directed_rows.push_back(table_row(OP_DIV, '0, 1, STAT_OK, 32'hFFFF_FFFD, 2));
      directed_rows.push_back(table_row(OP_PUSH, 5, 0, STAT_OK, '0, '0));
      directed_rows.push_back(table_row(OP_SUB, '0, 0, STAT_OK, '0, '0));
      directed_rows.push_back(table_row(OP_PUSH, 32'hAAAA_AAAA, 0, STAT_OK, '0, '0));
      directed_rows.push_back(table_row(OP_PUSH, 32'h5555_5555, 0, STAT_OK, '0, '0));
      directed_rows.push_back(table_row(OP_MUL, '0, 0, STAT_OK, '0, '0));
      directed_rows.push_back(table_row(OP_PUSH, 32'hFFFF_0000, 0, STAT_OK, '0, '0));
      directed_rows.push_back(table_row(OP_ADD, '0, 0, STAT_OK, '0, '0));
      directed_rows.push_back(table_row(OP_PUSH, 7, 0, STAT_OK, '0, '0));
      directed_rows.push_back(table_row(OP_PUSH, -32'sd2, 0, STAT_OK, '0, '0));
      directed_rows.push_back(table_row(OP_DIV, '0, 0, STAT_OK, '0, '0));
      directed_rows.push_back(table_row(OP_MUL, '0, 0, STAT_OK, '0, '0));

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < directed_rows.size(); i++)
         send_instr(directed_rows[i].op, directed_rows[i].imm, directed_rows[i].known,
                    directed_rows[i].res);

      // random streams that never halt; the push bias shifts so the stack
      // swings between empty and full
      taken = 0;
      while (taken < RANDOM_ITEMS) begin
         if ($urandom_range(0, 47) == 0) push_pct = $urandom_range(15, 90);
         roll = $urandom_range(0, 99);
         if (roll < 4) begin
            op = roll[0] ? OP_SPARE_7 : OP_SPARE_6;
         end else if (shadow_sp < 2 || (shadow_sp < STACK_DEPTH && roll < push_pct)) begin
            op = OP_PUSH;
         end else begin
            case ($urandom_range(0, 3))
               0:       op = OP_ADD;
               1:       op = OP_SUB;
               2:       op = OP_MUL;
               default: op = OP_DIV;
            endcase
            if (op == OP_DIV && shadow_stack[shadow_sp-1] == '0) op = OP_SUB;
         end
         case ($urandom_range(0, 9))
            0:       imm = '0;
            1:       imm = 1;
            2:       imm = MINUS_ONE;
            3:       imm = INT_MIN;
            4:       imm = INT_MAX;
            5, 6:    imm = $urandom_range(0, 200) - 100;
            default: imm = $urandom;
         endcase
         if (op != OP_SPARE_6 && op != OP_SPARE_7) taken++;
         send_instr(op, imm, 1'b0, '0);
      end

      // one way into the halted state, then requests that must be refused
      halt_kind = halt_kind_type'($urandom_range(0, 3));
      case (halt_kind)
         HALT_BY_END: begin
            send_instr(OP_END, $urandom, 1'b0, '0);
         end
         HALT_BY_OVERFLOW: begin
            while (shadow_sp < STACK_DEPTH) send_instr(OP_PUSH, $urandom, 1'b0, '0);
            send_instr(OP_PUSH, $urandom, 1'b0, '0);
         end
         HALT_BY_UNDERFLOW: begin
            while (shadow_sp >= 2) send_instr(OP_ADD, $urandom, 1'b0, '0);
            send_instr(OP_MUL, $urandom, 1'b0, '0);
         end
         default: begin
            if (shadow_sp == STACK_DEPTH) send_instr(OP_ADD, $urandom, 1'b0, '0);
            if (shadow_sp == 0) send_instr(OP_PUSH, 1, 1'b0, '0);
            send_instr(OP_PUSH, '0, 1'b0, '0);
            send_instr(OP_DIV, $urandom, 1'b0, '0);
         end
      endcase
      repeat ($urandom_range(4, 10)) send_instr($urandom_range(0, 7), $urandom, 1'b0, '0);

      req_bus.valid <= 1'b0;
      while (expected_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb_stack_machine_alu passed");
      else
         $display("tb_stack_machine_alu failed");
      $finish;
   end

endmodule
